>>> src/gaussian_plane_wave_field_eval_core_defines.svh
// Assertion macros shared by the plane-wave evaluator RTL.
// No dependencies; expects signals named clock and reset in the using scope.
`ifndef GAUSSIAN_PLANE_WAVE_FIELD_EVAL_CORE_DEFINES_SVH
`define GAUSSIAN_PLANE_WAVE_FIELD_EVAL_CORE_DEFINES_SVH

// cons must hold after ante, delayed by dly
`define GPWF_ASSERT_AFTER(lbl, ante, dly, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##(dly) (cons)) \
      else $error("gpwf: delayed check failed");

// cons implies ante was true, looking back by dly
`define GPWF_ASSERT_PAST(lbl, cons, ante, dly) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cons) |-> $past(ante, dly)) \
      else $error("gpwf: history check failed");

`endif

>>> src/gpwf_pkg.sv
// Shared types and constants for the plane-wave field evaluator.
// No dependencies.
package gpwf_pkg;

   localparam int POS_W   = 32;
   localparam int TIME_W  = 32;
   localparam int VEC_W   = 16;
   localparam int OUT_W   = 24;
   localparam int ARG_W   = 37;
   localparam int MAG_W   = 36;
   localparam int PH_W    = 32;
   localparam int R_W     = 21;
   localparam int REM_W   = 54;
   localparam int W_W     = 32;
   localparam int COEF_W  = 32;
   localparam int CSR_W   = 48;
   localparam int CIDX_W  = 3;

   localparam int DLY_STAGES  = 4;
   localparam int WAVE_STAGES = 5;
   localparam int OUT_STAGES  = 2;

   localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
   localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

   // region scale codes
   localparam logic [1:0] SC_ONE      = 2'd0;
   localparam logic [1:0] SC_POS_HALF = 2'd1;
   localparam logic [1:0] SC_NEG_HALF = 2'd2;

   // register indexes
   localparam logic [CIDX_W-1:0] CSR_DRIVE_MAGNETIC    = 3'd0;
   localparam logic [CIDX_W-1:0] CSR_MODULATED         = 3'd1;
   localparam logic [CIDX_W-1:0] CSR_APPLY_REGION_SIGN = 3'd2;
   localparam logic [CIDX_W-1:0] CSR_PULSE_SPREAD      = 3'd3;
   localparam logic [CIDX_W-1:0] CSR_PULSE_CENTER      = 3'd4;
   localparam logic [CIDX_W-1:0] CSR_CARRIER_FREQUENCY = 3'd5;
   localparam logic [CIDX_W-1:0] CSR_POLARIZATION_VEC  = 3'd6;
   localparam logic [CIDX_W-1:0] CSR_PROPAGATION_VEC   = 3'd7;

   typedef struct packed {
      logic               drive_magnetic;
      logic               modulated;
      logic               apply_region_sign;
      logic [31:0]        pulse_spread;
      logic signed [31:0] pulse_center;
      logic [31:0]        carrier_frequency;
      logic [CSR_W-1:0]   polarization_vec;
      logic [CSR_W-1:0]   propagation_vec;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic [MAG_W-1:0] mag;
      logic [PH_W-1:0]  ph;
      logic             ovf;
      logic [1:0]       sc;
   } dly_type;

   typedef struct packed {
      logic            valid;
      logic [R_W-1:0]  r;
      logic [PH_W-1:0] ph;
      logic            ovf;
      logic [1:0]      sc;
   } quo_type;

   typedef struct packed {
      logic                  valid;
      logic signed [W_W-1:0] w;
      logic [1:0]            sc;
   } wave_type;

   // zero spread acts as one LSB
   function automatic logic [31:0] sigma_eff(input logic [31:0] s);
      return (s == 32'd0) ? 32'd1 : s;
   endfunction

endpackage

>>> src/gpwf_delay.sv
// Front stages: dot product delay, pulse argument, carrier phase, range check.
// Depends on gpwf_pkg.
module gpwf_delay (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gpwf_pkg::cfg_type                    cfg,
   input  logic                                 in_valid,
   input  logic signed [gpwf_pkg::POS_W-1:0]    pos_x,
   input  logic signed [gpwf_pkg::POS_W-1:0]    pos_y,
   input  logic signed [gpwf_pkg::POS_W-1:0]    pos_z,
   input  logic [gpwf_pkg::TIME_W-1:0]          sim_time,
   input  logic [1:0]                           region_code,
   output gpwf_pkg::dly_type                    out
);
   logic signed [gpwf_pkg::VEC_W-1:0] k_x, k_y, k_z;
   logic signed [47:0] prx_in, pry_in, prz_in, prx_ff, pry_ff, prz_ff;
   logic [gpwf_pkg::TIME_W-1:0] t1_ff, t2_ff;
   logic [1:0] sc_in, sc1_ff, sc2_ff, sc3_ff;
   logic v1_ff, v2_ff, v3_ff;
   logic signed [49:0] dot_in, dot_ff, dot_rnd;
   logic signed [35:0] delay_s;
   logic signed [32:0] time_s;
   logic signed [gpwf_pkg::ARG_W-1:0] arg_in, arg_ff;
   logic [gpwf_pkg::MAG_W-1:0] mag_in;
   logic [31:0] sig;
   gpwf_pkg::dly_type out_in, out_ff;

   assign k_x = cfg.propagation_vec[15:0];
   assign k_y = cfg.propagation_vec[31:16];
   assign k_z = cfg.propagation_vec[47:32];

   assign prx_in = 48'(pos_x) * 48'(k_x);
   assign pry_in = 48'(pos_y) * 48'(k_y);
   assign prz_in = 48'(pos_z) * 48'(k_z);
   assign sc_in  = (cfg.apply_region_sign &&
                    (region_code == gpwf_pkg::SC_POS_HALF ||
                     region_code == gpwf_pkg::SC_NEG_HALF)) ? region_code : gpwf_pkg::SC_ONE;

   assign dot_in = 50'(prx_ff) + 50'(pry_ff) + 50'(prz_ff);

   // round half away from zero: add half, minus one when negative, then floor
   assign dot_rnd = dot_ff + 50'sd8192 - 50'(dot_ff[49]);
   assign delay_s = dot_rnd[49:14];
   assign time_s  = {1'b0, t2_ff};
   assign arg_in  = gpwf_pkg::ARG_W'(delay_s) - gpwf_pkg::ARG_W'(time_s)
                    - gpwf_pkg::ARG_W'(cfg.pulse_center);

   assign sig    = gpwf_pkg::sigma_eff(cfg.pulse_spread);
   assign mag_in = arg_ff[gpwf_pkg::ARG_W-1] ? gpwf_pkg::MAG_W'(-arg_ff)
                                             : gpwf_pkg::MAG_W'(arg_ff);

   always_comb begin
      out_in.valid = v3_ff;
      out_in.mag   = mag_in;
      out_in.ph    = gpwf_pkg::PH_W'(cfg.carrier_frequency * arg_ff[31:0]);
      // quotient would reach 2^21: envelope underflows
      out_in.ovf   = {1'b0, mag_in} >= {sig, 5'b0};
      out_in.sc    = sc3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_ff.valid <= out_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      prx_ff      <= prx_in;
      pry_ff      <= pry_in;
      prz_ff      <= prz_in;
      t1_ff       <= sim_time;
      sc1_ff      <= sc_in;
      dot_ff      <= dot_in;
      t2_ff       <= t1_ff;
      sc2_ff      <= sc1_ff;
      arg_ff      <= arg_in;
      sc3_ff      <= sc2_ff;
      out_ff.mag  <= out_in.mag;
      out_ff.ph   <= out_in.ph;
      out_ff.ovf  <= out_in.ovf;
      out_ff.sc   <= out_in.sc;
   end

   assign out = out_ff;
endmodule

>>> src/gpwf_div.sv
// Pipelined restoring divider: r = floor(mag * 2^16 / sigma), one quotient bit per stage.
// Depends on gpwf_pkg.
module gpwf_div (
   input  logic               clock,
   input  logic               reset,
   input  logic [31:0]        pulse_spread,
   input  gpwf_pkg::dly_type  in,
   output gpwf_pkg::quo_type  out
);
   localparam int STAGES = gpwf_pkg::R_W;

   logic [gpwf_pkg::REM_W-1:0] rem_ff [STAGES+1];
   logic [gpwf_pkg::REM_W-1:0] rem_in [STAGES];
   logic [gpwf_pkg::R_W-1:0]   q_ff   [STAGES+1];
   logic [gpwf_pkg::R_W-1:0]   q_in   [STAGES];
   logic [gpwf_pkg::PH_W-1:0]  ph_ff  [STAGES+1];
   logic                       ovf_ff [STAGES+1];
   logic [1:0]                 sc_ff  [STAGES+1];
   logic                       v_ff   [STAGES+1];
   logic [31:0]                sig;

   assign sig = gpwf_pkg::sigma_eff(pulse_spread);

   always_comb begin
      for (int j = 0; j < STAGES; j++) begin
         logic [gpwf_pkg::REM_W-1:0] dsh;
         dsh = gpwf_pkg::REM_W'(sig) << (STAGES - 1 - j);
         if (rem_ff[j] >= dsh) begin
            rem_in[j] = rem_ff[j] - dsh;
            q_in[j]   = q_ff[j] | (gpwf_pkg::R_W'(1) << (STAGES - 1 - j));
         end else begin
            rem_in[j] = rem_ff[j];
            q_in[j]   = q_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= STAGES; j++) v_ff[j] <= 1'b0;
      end else begin
         v_ff[0] <= in.valid;
         for (int j = 0; j < STAGES; j++) v_ff[j+1] <= v_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= gpwf_pkg::REM_W'({in.mag, 16'b0});
      q_ff[0]   <= '0;
      ph_ff[0]  <= in.ph;
      ovf_ff[0] <= in.ovf;
      sc_ff[0]  <= in.sc;
      for (int j = 0; j < STAGES; j++) begin
         rem_ff[j+1] <= rem_in[j];
         q_ff[j+1]   <= q_in[j];
         ph_ff[j+1]  <= ph_ff[j];
         ovf_ff[j+1] <= ovf_ff[j];
         sc_ff[j+1]  <= sc_ff[j];
      end
   end

   always_comb begin
      out.valid = v_ff[STAGES];
      out.r     = q_ff[STAGES];
      out.ph    = ph_ff[STAGES];
      out.ovf   = ovf_ff[STAGES];
      out.sc    = sc_ff[STAGES];
   end
endmodule

>>> src/gpwf_wave.sv
// Waveform stages: exp envelope and cosine carrier lookups and their product.
// Depends on gpwf_pkg; both tables are ROMs built at elaboration.
module gpwf_wave #(
   parameter int EXP_TABLE_DEPTH = 1024,
   parameter int COS_TABLE_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               modulated,
   input  gpwf_pkg::quo_type  in,
   output gpwf_pkg::wave_type out
);
   localparam int EA_W = $clog2(EXP_TABLE_DEPTH);
   localparam int CA_W = $clog2(COS_TABLE_DEPTH);
   localparam int U_W  = 2 * gpwf_pkg::R_W - 17;
   localparam int EI_W = U_W + $clog2(EXP_TABLE_DEPTH + 1) + 1;
   localparam int CP_W = gpwf_pkg::PH_W + $clog2(COS_TABLE_DEPTH + 1) + 1;
   localparam longint unsigned ONE_Q30     = 64'd1 << 30;
   localparam longint unsigned PI_Q30      = 64'd3373259426;
   localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef logic [30:0]        exp_rom_type [EXP_TABLE_DEPTH];
   typedef logic signed [31:0] cos_rom_type [COS_TABLE_DEPTH];

   function automatic exp_rom_type build_exp();
      exp_rom_type t;
      longint unsigned x, term, prev;
      longint ratio;
      x     = ((64'd16 << 30) + 64'(EXP_TABLE_DEPTH / 2)) / 64'(EXP_TABLE_DEPTH);
      term  = ONE_Q30;
      ratio = longint'(ONE_Q30);
      for (int n = 1; n <= 12; n++) begin
         term  = ((term * x) >> 30) / 64'(n);
         ratio = (n % 2 == 1) ? ratio - longint'(term) : ratio + longint'(term);
      end
      prev = ONE_Q30;
      t[0] = 31'(prev);
      for (int k = 1; k < EXP_TABLE_DEPTH; k++) begin
         prev = (prev * 64'(ratio) + (64'd1 << 29)) >> 30;
         t[k] = 31'(prev);
      end
      return t;
   endfunction

   function automatic cos_rom_type build_cos();
      cos_rom_type t;
      longint unsigned th, t2, term;
      longint sum;
      logic neg;
      for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
         th  = (TWO_PI_Q30 * 64'(k) + 64'(COS_TABLE_DEPTH / 2)) / 64'(COS_TABLE_DEPTH);
         neg = 1'b0;
         if (th > PI_Q30) th = (th > TWO_PI_Q30) ? 64'd0 : TWO_PI_Q30 - th;
         if (th > HALF_PI_Q30) begin
            th  = PI_Q30 - th;
            neg = 1'b1;
         end
         t2   = (th * th + (64'd1 << 29)) >> 30;
         term = ONE_Q30;
         sum  = longint'(ONE_Q30);
         for (int n = 1; n <= 10; n++) begin
            term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
            sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
         end
         if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
         if (sum < 0) sum = 0;
         t[k] = neg ? 32'(-sum) : 32'(sum);
      end
      return t;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp();
   localparam cos_rom_type COS_ROM = build_cos();

   logic [2*gpwf_pkg::R_W-1:0] rsq;
   logic [U_W-1:0]  u_ff;
   logic [CP_W-1:0] cprod;
   logic [CP_W-33:0] cfull;
   logic [CA_W-1:0] ci_in, ci1_ff, ci2_ff;
   logic [EI_W-1:0] eprod;
   logic [EI_W-21:0] efull;
   logic            eok_in, eok2_ff, eok3_ff, ovf1_ff;
   logic [EA_W-1:0] ea_in, ea_ff;
   logic [30:0]     exp_rd_ff;
   logic signed [31:0] cos_rd_ff, env_s, cos_s;
   logic signed [63:0] prod_in, prod_ff, prod_rnd;
   logic [1:0]      sc1_ff, sc2_ff, sc3_ff, sc4_ff, sc5_ff;
   logic            v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [gpwf_pkg::W_W-1:0] w_ff;

   assign rsq   = in.r * in.r;
   assign cprod = CP_W'(in.ph) * CP_W'(COS_TABLE_DEPTH) + (CP_W'(1) << 31);
   assign cfull = cprod[CP_W-1:32];
   assign ci_in = (cfull >= (CP_W-32)'(COS_TABLE_DEPTH)) ? '0 : cfull[CA_W-1:0];

   assign eprod  = EI_W'(u_ff) * EI_W'(EXP_TABLE_DEPTH) + (EI_W'(1) << 19);
   assign efull  = eprod[EI_W-1:20];
   assign eok_in = !ovf1_ff && (efull < (EI_W-20)'(EXP_TABLE_DEPTH));
   assign ea_in  = eok_in ? efull[EA_W-1:0] : '0;

   assign env_s    = eok3_ff ? {1'b0, exp_rd_ff} : 32'sd0;
   assign cos_s    = modulated ? cos_rd_ff : 32'sh40000000;
   assign prod_in  = 64'(env_s) * 64'(cos_s);
   assign prod_rnd = prod_ff + 64'sd536870912 - 64'(prod_ff[63]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      u_ff      <= rsq[2*gpwf_pkg::R_W-1:17];
      ci1_ff    <= ci_in;
      ovf1_ff   <= in.ovf;
      sc1_ff    <= in.sc;
      eok2_ff   <= eok_in;
      ea_ff     <= ea_in;
      ci2_ff    <= ci1_ff;
      sc2_ff    <= sc1_ff;
      exp_rd_ff <= EXP_ROM[ea_ff];
      cos_rd_ff <= COS_ROM[ci2_ff];
      eok3_ff   <= eok2_ff;
      sc3_ff    <= sc2_ff;
      prod_ff   <= prod_in;
      sc4_ff    <= sc3_ff;
      w_ff      <= prod_rnd[61:30];
      sc5_ff    <= sc4_ff;
   end

   always_comb begin
      out.valid = v5_ff;
      out.w     = w_ff;
      out.sc    = sc5_ff;
   end
endmodule

>>> src/gpwf_out.sv
// Output stages: field coefficients, six scale products, rounding and saturation.
// Depends on gpwf_pkg and the shared assertion macros.
`include "gaussian_plane_wave_field_eval_core_defines.svh"
module gpwf_out (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gpwf_pkg::cfg_type                    cfg,
   input  gpwf_pkg::wave_type                   in,
   output logic                                 rsp_valid,
   output logic signed [gpwf_pkg::OUT_W-1:0]    rsp_e_x,
   output logic signed [gpwf_pkg::OUT_W-1:0]    rsp_e_y,
   output logic signed [gpwf_pkg::OUT_W-1:0]    rsp_e_z,
   output logic signed [gpwf_pkg::OUT_W-1:0]    rsp_h_x,
   output logic signed [gpwf_pkg::OUT_W-1:0]    rsp_h_y,
   output logic signed [gpwf_pkg::OUT_W-1:0]    rsp_h_z
);
   function automatic logic signed [gpwf_pkg::OUT_W-1:0] to_out(
      input logic signed [63:0] pr,
      input logic [1:0]         sc
   );
      logic [63:0] r38, r39;
      logic signed [26:0] v;
      r38 = pr + (64'd1 << 37) - 64'(pr[63]);
      r39 = pr + (64'd1 << 38) - 64'(pr[63]);
      v   = (sc == gpwf_pkg::SC_ONE) ? 27'(signed'(r38[63:38])) : 27'(signed'(r39[63:39]));
      if (sc == gpwf_pkg::SC_NEG_HALF) v = -v;
      if (v > 27'(gpwf_pkg::OUT_MAX)) return gpwf_pkg::OUT_MAX;
      if (v < 27'(gpwf_pkg::OUT_MIN)) return gpwf_pkg::OUT_MIN;
      return v[gpwf_pkg::OUT_W-1:0];
   endfunction

   logic signed [gpwf_pkg::VEC_W-1:0] p [3];
   logic signed [gpwf_pkg::VEC_W-1:0] k [3];
   logic signed [gpwf_pkg::COEF_W-1:0] kp_ff [6];
   logic signed [gpwf_pkg::COEF_W-1:0] cr [3];
   logic signed [gpwf_pkg::COEF_W-1:0] pe [3];
   logic signed [gpwf_pkg::COEF_W-1:0] coef_ff [6];
   logic signed [63:0] prod_ff [6];
   logic [1:0] sc_ff;
   logic       v_ff;
   logic       rsp_valid_ff;
   logic signed [gpwf_pkg::OUT_W-1:0] rsp_ff [6];
   logic       rsp_zero;

   always_comb begin
      for (int d = 0; d < 3; d++) begin
         p[d]  = cfg.polarization_vec[16*d +: 16];
         k[d]  = cfg.propagation_vec[16*d +: 16];
         // p is Q.14; shift so every coefficient shares the cross product's Q.28
         pe[d] = gpwf_pkg::COEF_W'(p[d]) <<< 14;
      end
      cr[0] = kp_ff[0] - kp_ff[1];
      cr[1] = kp_ff[2] - kp_ff[3];
      cr[2] = kp_ff[4] - kp_ff[5];
   end

   // coefficients follow the registers; they settle long before a transaction reaches here
   always_ff @(posedge clock) begin
      kp_ff[0] <= gpwf_pkg::COEF_W'(k[1]) * gpwf_pkg::COEF_W'(p[2]);
      kp_ff[1] <= gpwf_pkg::COEF_W'(k[2]) * gpwf_pkg::COEF_W'(p[1]);
      kp_ff[2] <= gpwf_pkg::COEF_W'(k[2]) * gpwf_pkg::COEF_W'(p[0]);
      kp_ff[3] <= gpwf_pkg::COEF_W'(k[0]) * gpwf_pkg::COEF_W'(p[2]);
      kp_ff[4] <= gpwf_pkg::COEF_W'(k[0]) * gpwf_pkg::COEF_W'(p[1]);
      kp_ff[5] <= gpwf_pkg::COEF_W'(k[1]) * gpwf_pkg::COEF_W'(p[0]);
      for (int d = 0; d < 3; d++) begin
         coef_ff[d]   <= cfg.drive_magnetic ? -cr[d] : pe[d];
         coef_ff[d+3] <= cfg.drive_magnetic ? pe[d] : cr[d];
      end
      for (int d = 0; d < 6; d++) begin
         prod_ff[d] <= 64'(in.w) * 64'(coef_ff[d]);
         rsp_ff[d]  <= to_out(prod_ff[d], sc_ff);
      end
      sc_ff <= in.sc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v_ff         <= in.valid;
         rsp_valid_ff <= v_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_e_x   = rsp_ff[0];
   assign rsp_e_y   = rsp_ff[1];
   assign rsp_e_z   = rsp_ff[2];
   assign rsp_h_x   = rsp_ff[3];
   assign rsp_h_y   = rsp_ff[4];
   assign rsp_h_z   = rsp_ff[5];

   assign rsp_zero = rsp_e_x == 0 && rsp_e_y == 0 && rsp_e_z == 0 &&
                     rsp_h_x == 0 && rsp_h_y == 0 && rsp_h_z == 0;

   // a zero waveform gives six zero components whatever the coefficients
   `GPWF_ASSERT_AFTER(a_zero_wave, in.valid && in.w == 0, 2, rsp_valid && rsp_zero)
endmodule

>>> src/gaussian_plane_wave_field_eval_core.sv
// An accepted transaction runs through delay, divider, wave and output stages to rsp_valid.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the 21-stage restoring divider, one quotient bit per stage.
// Reset clears the valid bits and loads register defaults; in-flight work is dropped.
// Depends on gpwf_pkg, gpwf_delay, gpwf_div, gpwf_wave, gpwf_out and the assertion macros.
`include "gaussian_plane_wave_field_eval_core_defines.svh"
module gaussian_plane_wave_field_eval_core #(
   parameter int EXP_TABLE_DEPTH = 1024,
   parameter int COS_TABLE_DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [gpwf_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [gpwf_pkg::POS_W-1:0]    req_pos_y,
   input  logic signed [gpwf_pkg::POS_W-1:0]    req_pos_z,
   input  logic [gpwf_pkg::TIME_W-1:0]          req_sim_time,
   input  logic [1:0]                           req_region_code,
   output logic                                 rsp_valid,
   output logic signed [gpwf_pkg::OUT_W-1:0]    rsp_e_x,
   output logic signed [gpwf_pkg::OUT_W-1:0]    rsp_e_y,
   output logic signed [gpwf_pkg::OUT_W-1:0]    rsp_e_z,
   output logic signed [gpwf_pkg::OUT_W-1:0]    rsp_h_x,
   output logic signed [gpwf_pkg::OUT_W-1:0]    rsp_h_y,
   output logic signed [gpwf_pkg::OUT_W-1:0]    rsp_h_z,
   input  logic                                 csr_we,
   input  logic [gpwf_pkg::CIDX_W-1:0]          csr_index,
   input  logic [gpwf_pkg::CSR_W-1:0]           csr_wdata
);
   localparam int LATENCY = gpwf_pkg::DLY_STAGES + gpwf_pkg::R_W + 1
                            + gpwf_pkg::WAVE_STAGES + gpwf_pkg::OUT_STAGES;

   gpwf_pkg::cfg_type  cfg_ff;
   gpwf_pkg::dly_type  dly;
   gpwf_pkg::quo_type  quo;
   gpwf_pkg::wave_type wave;
   logic               accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive_magnetic    <= 1'b0;
         cfg_ff.modulated         <= 1'b0;
         cfg_ff.apply_region_sign <= 1'b0;
         cfg_ff.pulse_spread      <= 32'd65536;
         cfg_ff.pulse_center      <= '0;
         cfg_ff.carrier_frequency <= '0;
         cfg_ff.polarization_vec  <= '0;
         cfg_ff.propagation_vec   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            gpwf_pkg::CSR_DRIVE_MAGNETIC:    cfg_ff.drive_magnetic    <= csr_wdata[0];
            gpwf_pkg::CSR_MODULATED:         cfg_ff.modulated         <= csr_wdata[0];
            gpwf_pkg::CSR_APPLY_REGION_SIGN: cfg_ff.apply_region_sign <= csr_wdata[0];
            gpwf_pkg::CSR_PULSE_SPREAD:      cfg_ff.pulse_spread      <= csr_wdata[31:0];
            gpwf_pkg::CSR_PULSE_CENTER:      cfg_ff.pulse_center      <= csr_wdata[31:0];
            gpwf_pkg::CSR_CARRIER_FREQUENCY: cfg_ff.carrier_frequency <= csr_wdata[31:0];
            gpwf_pkg::CSR_POLARIZATION_VEC:  cfg_ff.polarization_vec  <= csr_wdata;
            gpwf_pkg::CSR_PROPAGATION_VEC:   cfg_ff.propagation_vec   <= csr_wdata;
         endcase
      end
   end

   gpwf_delay u_delay (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (accept),
      .pos_x       (req_pos_x),
      .pos_y       (req_pos_y),
      .pos_z       (req_pos_z),
      .sim_time    (req_sim_time),
      .region_code (req_region_code),
      .out         (dly)
   );

   gpwf_div u_div (
      .clock        (clock),
      .reset        (reset),
      .pulse_spread (cfg_ff.pulse_spread),
      .in           (dly),
      .out          (quo)
   );

   gpwf_wave #(
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
   ) u_wave (
      .clock     (clock),
      .reset     (reset),
      .modulated (cfg_ff.modulated),
      .in        (quo),
      .out       (wave)
   );

   gpwf_out u_out (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in        (wave),
      .rsp_valid (rsp_valid),
      .rsp_e_x   (rsp_e_x),
      .rsp_e_y   (rsp_e_y),
      .rsp_e_z   (rsp_e_z),
      .rsp_h_x   (rsp_h_x),
      .rsp_h_y   (rsp_h_y),
      .rsp_h_z   (rsp_h_z)
   );

   // every transaction comes out after the fixed depth, and nothing else does
   `GPWF_ASSERT_AFTER(a_result_follows, accept, LATENCY, rsp_valid)
   `GPWF_ASSERT_PAST(a_result_had_cause, rsp_valid, accept, LATENCY)
   `GPWF_ASSERT_AFTER(a_no_busy, 1'b1, 0, !busy)
endmodule
